// ===== hdl/pcpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpu_pkg
// Shared types and codes of the prefix code pack/unpack unit.
// ----------------------------------------------------------------------------
package pcpu_pkg;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 9;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_ENC  = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;
  localparam logic [1:0] ACT_DEC  = 2'd3;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_SYM  = 2'd1;
  localparam logic [1:0] KIND_STAT = 2'd2;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_NOCODE = 2'd1;
  localparam logic [1:0] ERR_EMPTY  = 2'd2;
  localparam logic [1:0] ERR_LONG   = 2'd3;

  localparam logic [2:0] EM_PACK = 3'd0;
  localparam logic [2:0] EM_PAD  = 3'd1;
  localparam logic [2:0] EM_SYM  = 3'd2;
  localparam logic [2:0] EM_ERR  = 3'd3;
  localparam logic [2:0] EM_END  = 3'd4;

  typedef struct packed {
    logic       capture;
    logic       mem_wr;
    logic       rd_scan;
    logic       enc_load;
    logic       enc_shift;
    logic       end_clear;
    logic       dec_start;
    logic       dec_shift;
    logic       scan_clr;
    logic       scan_inc;
    logic       buf_clr;
    logic       bit_inc;
    logic       emit;
    logic [2:0] emit_sel;
    logic [1:0] emit_err;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       tbl_empty;
    logic       sym_bad;
    logic       sym_unused;
    logic       len_bad;
    logic       enc_last;
    logic       pack_full;
    logic       pack_nz;
    logic       hit;
    logic       scan_last;
    logic       limit;
    logic       bit_last;
    logic       fin;
    logic       slot_free;
    logic       pend_v;
  } sts_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] value;
    logic [3:0]        used;
    logic [1:0]        err;
  } res_t;

endpackage

// ===== hdl/prefix_code_pack_unpack_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_pack_unpack_unit
// Prefix code table with bit packer (encode) and bit matcher (decode).
// ----------------------------------------------------------------------------
// Input words carry an action in in_tuser: load a table entry, encode a
// symbol, end an encoded message, or decode a packed byte (in_tlast marks
// the last byte of a coded message). Results leave on the out_ channel as
// packed bytes, decoded symbols or status words; out_tlast marks the last
// result caused by an input word.
// One word is worked on at a time. Decode matches every bit by scanning
// the code table through its single registered read port.
// Results pass through a pending slot and an output register, so the block
// keeps working while one result waits; when the receiver stalls and both
// are full the sequencer holds, and in_tready stays low until the word is
// done. Reset clears the table (all entries unused), the packer and the
// match buffer at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module prefix_code_pack_unpack_unit #(
  parameter int ALPHABET_SIZE = 256,
  parameter int MAX_CODE_LEN  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // symbol[7:0], code_word[39:8], code_length[45:40], coded_byte[53:46],
  // tail_bits[56:54], zero[63:57]
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,  // action
  input  logic        in_tlast,  // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_value[7:0], used_bits[11:8], error[13:12], zero[15:14]
  output logic [15:0] out_tdata,
  output logic [1:0]  out_tuser, // kind
  output logic        out_tlast  // last
);
  import pcpu_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t res;

  pcpu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcpu_dp #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_CODE_LEN  (MAX_CODE_LEN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_tuser),
    .in_symbol      (in_tdata[7:0]),
    .in_code_word   (in_tdata[39:8]),
    .in_code_length (in_tdata[45:40]),
    .in_coded_byte  (in_tdata[53:46]),
    .in_final_byte  (in_tlast),
    .in_tail_bits   (in_tdata[56:54]),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_tready),
    .out_valid      (out_tvalid),
    .out_res        (res),
    .out_last       (out_tlast)
  );

  assign out_tdata = {2'b00, res.err, res.used, res.value};
  assign out_tuser = res.kind;

endmodule

// ===== hdl/pcpu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpu_ctrl
// Sequencer: dispatches each word and steps encode, end and decode work.
// ----------------------------------------------------------------------------
module pcpu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcpu_pkg::sts_t sts,
  output pcpu_pkg::cmd_t cmd
);
  import pcpu_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_ENC_LD  = 4'd2;
  localparam logic [3:0] S_ENC_SH  = 4'd3;
  localparam logic [3:0] S_END_PAD = 4'd4;
  localparam logic [3:0] S_END_ST  = 4'd5;
  localparam logic [3:0] S_DEC_SH  = 4'd6;
  localparam logic [3:0] S_DEC_RD  = 4'd7;
  localparam logic [3:0] S_DEC_CMP = 4'd8;
  localparam logic [3:0] S_DEC_NX  = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.action)
          ACT_LOAD: begin
            if (sts.sym_bad || sts.len_bad) begin
              if (sts.slot_free) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_ERR;
                cmd.emit_err = sts.sym_bad ? ERR_NOCODE : ERR_LONG;
                state_nxt    = S_FIN;
              end
            end else begin
              cmd.mem_wr = 1'b1;
              state_nxt  = S_FIN;
            end
          end
          ACT_ENC: begin
            if (sts.tbl_empty || sts.sym_bad || sts.sym_unused) begin
              if (sts.slot_free) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_ERR;
                cmd.emit_err = sts.tbl_empty ? ERR_EMPTY : ERR_NOCODE;
                state_nxt    = S_FIN;
              end
            end else begin
              state_nxt = S_ENC_LD;
            end
          end
          ACT_END: begin
            state_nxt = sts.pack_nz ? S_END_PAD : S_END_ST;
          end
          default: begin
            if (sts.tbl_empty) begin
              if (sts.slot_free) begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = EM_ERR;
                cmd.emit_err = ERR_EMPTY;
                state_nxt    = S_FIN;
              end
            end else begin
              cmd.dec_start = 1'b1;
              state_nxt     = S_DEC_SH;
            end
          end
        endcase
      end
      S_ENC_LD: begin
        cmd.enc_load = 1'b1;
        state_nxt    = S_ENC_SH;
      end
      S_ENC_SH: begin
        if (!sts.pack_full || sts.slot_free) begin
          cmd.enc_shift = 1'b1;
          cmd.emit      = sts.pack_full;
          cmd.emit_sel  = EM_PACK;
          if (sts.enc_last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_END_PAD: begin
        if (sts.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_PAD;
          state_nxt    = S_END_ST;
        end
      end
      S_END_ST: begin
        if (sts.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EM_END;
          cmd.end_clear = 1'b1;
          state_nxt     = S_FIN;
        end
      end
      S_DEC_SH: begin
        cmd.dec_shift = 1'b1;
        cmd.scan_clr  = 1'b1;
        state_nxt     = S_DEC_RD;
      end
      S_DEC_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_DEC_CMP;
      end
      S_DEC_CMP: begin
        // keep the scanned entry on the read port while the output stalls
        cmd.rd_scan = 1'b1;
        if (sts.hit) begin
          if (sts.slot_free) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_SYM;
            cmd.buf_clr  = 1'b1;
            state_nxt    = S_DEC_NX;
          end
        end else if (sts.scan_last) begin
          if (!sts.limit) begin
            state_nxt = S_DEC_NX;
          end else if (sts.slot_free) begin
            // no code matched within the longest length
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_ERR;
            cmd.emit_err = ERR_LONG;
            cmd.buf_clr  = 1'b1;
            state_nxt    = S_DEC_NX;
          end
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = S_DEC_RD;
        end
      end
      S_DEC_NX: begin
        cmd.bit_inc = 1'b1;
        if (sts.bit_last) begin
          cmd.buf_clr = sts.fin;
          state_nxt   = S_FIN;
        end else begin
          state_nxt = S_DEC_SH;
        end
      end
      S_FIN: begin
        if (!sts.pend_v || sts.slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.emit || sts.slot_free)
    else $error("result pushed while output slot busy");
  a_rdy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.emit && !cmd.finish)
    else $error("result pushed while idle");
  a_cap_disp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_DISP)
    else $error("capture not followed by dispatch");

endmodule

// ===== hdl/pcpu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcpu_dp
// Datapath: code table memory, bit packer, match buffer and result slots.
// ----------------------------------------------------------------------------
module pcpu_dp #(
  parameter int ALPHABET_SIZE = 256,
  parameter int MAX_CODE_LEN  = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              in_action,
  input  logic [pcpu_pkg::SYM_W-1:0]  in_symbol,
  input  logic [pcpu_pkg::CODE_W-1:0] in_code_word,
  input  logic [pcpu_pkg::LEN_W-1:0]  in_code_length,
  input  logic [pcpu_pkg::BYTE_W-1:0] in_coded_byte,
  input  logic                    in_final_byte,
  input  logic [2:0]              in_tail_bits,
  input  pcpu_pkg::cmd_t          cmd,
  output pcpu_pkg::sts_t          sts,
  input  logic                    out_ready,
  output logic                    out_valid,
  output pcpu_pkg::res_t          out_res,
  output logic                    out_last
);
  import pcpu_pkg::*;

  localparam int LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int IW    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int ENT_W = LEN_W + CODE_W;

  // captured word
  logic [1:0]        act_r;
  logic [SYM_W-1:0]  sym_r;
  logic [CODE_W-1:0] word_r;
  logic [LEN_W-1:0]  len_r;
  logic [BYTE_W-1:0] byte_r;
  logic              fin_r;
  logic [2:0]        tail_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_action;
      sym_r  <= in_symbol;
      word_r <= in_code_word;
      len_r  <= in_code_length;
      byte_r <= in_coded_byte;
      fin_r  <= in_final_byte;
      tail_r <= in_tail_bits;
    end
  end

  logic [IW-1:0] sym_idx;
  logic          sym_bad;
  assign sym_idx = sym_r[IW-1:0];
  assign sym_bad = ({1'b0, sym_r} >= 9'(ALPHABET_SIZE));

  // code table: {length, bits}, one write and one registered read port
  logic [ENT_W-1:0]  mem [ALPHABET_SIZE];
  logic [ENT_W-1:0]  rd_r;
  logic [IW-1:0]     scan_r;
  logic [IW-1:0]     rd_addr;
  logic [CODE_W-1:0] wr_mask;

  assign rd_addr = cmd.rd_scan ? scan_r : sym_idx;
  assign wr_mask = CODE_W'((33'd1 << len_r) - 33'd1);

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[sym_idx] <= {len_r, word_r & wr_mask};
    end
    rd_r <= mem[rd_addr];
  end

  // entries in use, cleared at reset
  logic [ALPHABET_SIZE-1:0] used_r;
  logic [CNT_W-1:0]         used_cnt_r;
  logic                     old_used;
  logic                     new_used;
  assign old_used = used_r[sym_idx];
  assign new_used = (len_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      used_cnt_r <= '0;
    end else if (cmd.mem_wr) begin
      used_r[sym_idx] <= new_used;
      if (new_used && !old_used) begin
        used_cnt_r <= used_cnt_r + 1'b1;
      end else if (!new_used && old_used) begin
        used_cnt_r <= used_cnt_r - 1'b1;
      end
    end
  end

  // encoder shifter and bit packer
  logic [CODE_W-1:0] enc_code_r;
  logic [LEN_W-1:0]  enc_cnt_r;
  logic [7:0]        pack_r;
  logic [2:0]        pack_cnt_r;
  logic              nonempty_r;
  logic              enc_bit;
  logic [7:0]        pack_nxt;

  assign enc_bit  = enc_code_r[5'(enc_cnt_r - 1'b1)];
  assign pack_nxt = {pack_r[6:0], enc_bit};

  always_ff @(posedge clk) begin
    if (cmd.enc_load) begin
      enc_code_r <= rd_r[CODE_W-1:0];
      enc_cnt_r  <= rd_r[ENT_W-1:CODE_W];
    end else if (cmd.enc_shift) begin
      enc_cnt_r <= enc_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_r     <= '0;
      pack_cnt_r <= '0;
      nonempty_r <= 1'b0;
    end else if (cmd.end_clear) begin
      pack_r     <= '0;
      pack_cnt_r <= '0;
      nonempty_r <= 1'b0;
    end else begin
      if (cmd.enc_load) begin
        nonempty_r <= 1'b1;
      end
      if (cmd.enc_shift) begin
        pack_r     <= (pack_cnt_r == 3'd7) ? 8'd0 : pack_nxt;
        pack_cnt_r <= pack_cnt_r + 1'b1;
      end
    end
  end

  // decoder match buffer
  logic [CODE_W-1:0] mbuf_r;
  logic [LEN_W-1:0]  mlen_r;
  logic [3:0]        bit_idx_r;
  logic [3:0]        nbits;
  logic              dec_bit;

  assign nbits   = (fin_r && tail_r != 3'd0) ? {1'b0, tail_r} : 4'd8;
  assign dec_bit = byte_r[3'(3'd7 - bit_idx_r[2:0])];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbuf_r <= '0;
      mlen_r <= '0;
    end else if (cmd.buf_clr) begin
      mbuf_r <= '0;
      mlen_r <= '0;
    end else if (cmd.dec_shift) begin
      mbuf_r <= {mbuf_r[CODE_W-2:0], dec_bit};
      mlen_r <= mlen_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dec_start) begin
      bit_idx_r <= '0;
    end else if (cmd.bit_inc) begin
      bit_idx_r <= bit_idx_r + 1'b1;
    end
    if (cmd.scan_clr) begin
      scan_r <= '0;
    end else if (cmd.scan_inc) begin
      scan_r <= scan_r + 1'b1;
    end
  end

  // buffer holds exactly mlen_r bits, so no mask is needed
  logic hit;
  assign hit = used_r[scan_r] && (rd_r[ENT_W-1:CODE_W] == mlen_r)
               && (rd_r[CODE_W-1:0] == mbuf_r);

  // result slots: pending holds the newest result until its last flag is known
  logic  pend_v_r;
  res_t  pend_r;
  logic  out_v_r;
  res_t  out_r;
  logic  out_last_r;
  logic  slot_free;
  res_t  new_res;
  logic  tbl_empty;

  assign tbl_empty = (used_cnt_r == '0);
  assign slot_free = !out_v_r || out_ready;

  always_comb begin
    new_res = '0;
    case (cmd.emit_sel)
      EM_PACK: begin
        new_res.kind  = KIND_BYTE;
        new_res.value = pack_nxt;
      end
      EM_PAD: begin
        new_res.kind  = KIND_BYTE;
        new_res.value = pack_r << (4'd8 - {1'b0, pack_cnt_r});
      end
      EM_SYM: begin
        new_res.kind  = KIND_SYM;
        new_res.value = BYTE_W'(scan_r);
      end
      EM_END: begin
        new_res.kind = KIND_STAT;
        new_res.err  = tbl_empty ? ERR_EMPTY : ERR_NONE;
        if (pack_cnt_r != 3'd0) begin
          new_res.used = {1'b0, pack_cnt_r};
        end else begin
          new_res.used = nonempty_r ? 4'd0 : 4'd8;
        end
      end
      default: begin
        new_res.kind = KIND_STAT;
        new_res.err  = cmd.emit_err;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end
      if ((cmd.emit || cmd.finish) && pend_v_r) begin
        out_v_r <= 1'b1;
      end
      if (cmd.emit) begin
        pend_v_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.emit || cmd.finish) && pend_v_r) begin
      out_r      <= pend_r;
      out_last_r <= cmd.finish;
    end
    if (cmd.emit) begin
      pend_r <= new_res;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

  always_comb begin
    sts            = '0;
    sts.action     = act_r;
    sts.tbl_empty  = tbl_empty;
    sts.sym_bad    = sym_bad;
    sts.sym_unused = !sym_bad && !old_used;
    sts.len_bad    = (len_r > LEN_W'(LIMIT));
    sts.enc_last   = (enc_cnt_r == LEN_W'(1));
    sts.pack_full  = (pack_cnt_r == 3'd7);
    sts.pack_nz    = (pack_cnt_r != 3'd0);
    sts.hit        = hit;
    sts.scan_last  = (scan_r == IW'(ALPHABET_SIZE - 1));
    sts.limit      = (mlen_r >= LEN_W'(LIMIT));
    sts.bit_last   = ((bit_idx_r + 1'b1) == nbits);
    sts.fin        = fin_r;
    sts.slot_free  = slot_free;
    sts.pend_v     = pend_v_r;
  end

  a_mlen: assert property (@(posedge clk) disable iff (!rst_n)
    mlen_r <= LEN_W'(LIMIT))
    else $error("match buffer longer than code limit");
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && !cmd.emit |=> !pend_v_r)
    else $error("pending result left after finish");
  a_cnt_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (used_cnt_r == '0) == (used_r == '0))
    else $error("used count out of step with used bits");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the prefix code pack/unpack unit.
// ----------------------------------------------------------------------------
// Fills a queue of input words: a short directed part first, then random
// code tables, messages that are encoded and decoded back, and noise words.
// Expected results are computed for each word as it is queued. A clocked
// driver and a clocked monitor move words with random gaps on both sides.
// The monitor checks every result word field by field against the oldest
// expectation.
// ----------------------------------------------------------------------------
module tb_top;
  import pcpu_pkg::*;

  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  sym;
    logic [31:0] code;
    logic [5:0]  len;
    logic [7:0]  byt;
    logic        fin;
    logic [2:0]  tail;
  } op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [3:0] used;
    logic [1:0] err;
    logic       last;
  } outw_t;

  localparam int CODE_LIMIT = 32;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  op_t   op_q[$];
  outw_t result_q[$];
  int    sent_cnt;
  int    err_cnt;

  // shadow state of the unit
  logic [31:0] tbl_code[256];
  logic [5:0]  tbl_len[256];
  logic [7:0]  pk_bits;
  logic [2:0]  pk_cnt;
  logic        msg_open;
  logic [31:0] mbuf;
  logic [5:0]  mlen;

  prefix_code_pack_unpack_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] len_mask(input int n);
    logic [63:0] m;
    m = (64'd1 << n) - 64'd1;
    return m[31:0];
  endfunction

  function automatic bit table_empty();
    for (int i = 0; i < 256; i++) begin
      if (tbl_len[i] != 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void post(input logic [1:0] k, input logic [7:0] v,
                               input logic [3:0] u, input logic [1:0] e);
    outw_t r;
    r.kind = k; r.value = v; r.used = u; r.err = e; r.last = 1'b0;
    result_q.push_back(r);
  endfunction

  function automatic void pack_bit(input logic b);
    pk_bits = {pk_bits[6:0], b};
    pk_cnt = pk_cnt + 3'd1;
    if (pk_cnt == 3'd0) begin
      post(KIND_BYTE, pk_bits, 4'd0, ERR_NONE);
      pk_bits = 8'd0;
    end
  endfunction

  function automatic void predict(input op_t w);
    int n0;
    int nb;
    int hit;
    n0 = result_q.size();
    case (w.act)
      ACT_LOAD: begin
        if (w.len > CODE_LIMIT) begin
          post(KIND_STAT, 8'd0, 4'd0, ERR_LONG);
        end else begin
          tbl_len[w.sym] = w.len;
          tbl_code[w.sym] = w.code & len_mask(w.len);
        end
      end
      ACT_ENC: begin
        if (table_empty()) begin
          post(KIND_STAT, 8'd0, 4'd0, ERR_EMPTY);
        end else if (tbl_len[w.sym] == 0) begin
          post(KIND_STAT, 8'd0, 4'd0, ERR_NOCODE);
        end else begin
          msg_open = 1'b1;
          for (int i = tbl_len[w.sym]; i > 0; i--) pack_bit(tbl_code[w.sym][i-1]);
        end
      end
      ACT_END: begin
        logic [3:0] u;
        if (pk_cnt != 0) begin
          post(KIND_BYTE, pk_bits << (8 - pk_cnt), 4'd0, ERR_NONE);
          u = {1'b0, pk_cnt};
        end else begin
          u = msg_open ? 4'd0 : 4'd8;
        end
        post(KIND_STAT, 8'd0, u, table_empty() ? ERR_EMPTY : ERR_NONE);
        pk_bits = 8'd0;
        pk_cnt = 3'd0;
        msg_open = 1'b0;
      end
      default: begin
        if (table_empty()) begin
          post(KIND_STAT, 8'd0, 4'd0, ERR_EMPTY);
        end else begin
          nb = (w.fin && w.tail != 0) ? w.tail : 8;
          for (int b = 0; b < nb; b++) begin
            mbuf = {mbuf[30:0], w.byt[7-b]};
            mlen = mlen + 6'd1;
            hit = -1;
            for (int s = 0; s < 256; s++) begin
              if (hit < 0 && tbl_len[s] == mlen && tbl_code[s] == (mbuf & len_mask(mlen)))
                hit = s;
            end
            if (hit >= 0) begin
              post(KIND_SYM, hit[7:0], 4'd0, ERR_NONE);
              mbuf = 32'd0; mlen = 6'd0;
            end else if (mlen >= CODE_LIMIT) begin
              post(KIND_STAT, 8'd0, 4'd0, ERR_LONG);
              mbuf = 32'd0; mlen = 6'd0;
            end
          end
          if (w.fin) begin
            mbuf = 32'd0; mlen = 6'd0;
          end
        end
      end
    endcase
    if (result_q.size() > n0) result_q[result_q.size()-1].last = 1'b1;
  endfunction

  task automatic queue_op(input logic [1:0] a, input logic [7:0] s, input logic [31:0] c,
                          input logic [5:0] l, input logic [7:0] b, input logic f,
                          input logic [2:0] t);
    op_t w;
    w.act = a; w.sym = s; w.code = c; w.len = l; w.byt = b; w.fin = f; w.tail = t;
    op_q.push_back(w);
    predict(w);
  endtask

  task automatic queue_noise();
    queue_op(2'($urandom_range(3)), 8'($urandom), $urandom, 6'($urandom_range(63)),
             8'($urandom), 1'($urandom_range(1)), 3'($urandom_range(7)));
  endtask

  // encode a symbol list, end the message, then feed the packed bytes back
  task automatic encode_decode(input int syms[$], input bit messy);
    int n0;
    logic [7:0] bytes[$];
    logic [3:0] u;
    logic [7:0] b;
    bit f;
    n0 = result_q.size();
    foreach (syms[i]) queue_op(ACT_ENC, 8'(syms[i]), $urandom, 6'($urandom), 8'($urandom),
                               1'($urandom), 3'($urandom));
    queue_op(ACT_END, 8'($urandom), $urandom, 6'($urandom), 8'($urandom), 1'($urandom),
             3'($urandom));
    u = result_q[result_q.size()-1].used;
    for (int i = n0; i < result_q.size(); i++) begin
      if (result_q[i].kind == KIND_BYTE) bytes.push_back(result_q[i].value);
    end
    foreach (bytes[i]) begin
      b = bytes[i];
      f = (i == bytes.size() - 1);
      if (messy && $urandom_range(9) == 0) b = b ^ (8'd1 << $urandom_range(7));
      if (messy && f && $urandom_range(9) == 0) f = 1'b0;
      queue_op(ACT_DEC, 8'($urandom), $urandom, 6'($urandom), b, f,
               f ? u[2:0] : 3'($urandom_range(7)));
    end
  endtask

  task automatic fill_stimulus();
    int syms[$];
    logic [31:0] lf_bits[$];
    int lf_len[$];
    int k;
    int m;
    int s;
    bit taken[256];
    // empty table cases and overlong code loads
    queue_op(ACT_ENC, 8'd5, 32'd0, 6'd0, 8'd0, 1'b0, 3'd0);
    queue_op(ACT_END, 8'd0, 32'd0, 6'd0, 8'd0, 1'b0, 3'd0);
    queue_op(ACT_DEC, 8'd0, 32'd0, 6'd0, 8'hA5, 1'b1, 3'd0);
    queue_op(ACT_LOAD, 8'd9, 32'd1, 6'd40, 8'd0, 1'b0, 3'd0);
    queue_op(ACT_LOAD, 8'd9, 32'd1, 6'd63, 8'd0, 1'b0, 3'd0);
    // small code with stray upper bits, a 32-bit code and a duplicate
    queue_op(ACT_LOAD, 8'd0, 32'hFFFF_FFFE, 6'd1, 8'd0, 1'b0, 3'd0);
    queue_op(ACT_LOAD, 8'd1, 32'hAAAA_AAAA, 6'd2, 8'd0, 1'b0, 3'd0);
    queue_op(ACT_LOAD, 8'd2, 32'h0000_0003, 6'd2, 8'd0, 1'b0, 3'd0);
    queue_op(ACT_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32, 8'd0, 1'b0, 3'd0);
    queue_op(ACT_LOAD, 8'd3, 32'h5555_5556, 6'd2, 8'd0, 1'b0, 3'd0);
    syms = '{0, 1, 2, 7, 255, 3, 0};
    encode_decode(syms, 1'b0);
    queue_op(ACT_DEC, 8'd0, 32'd0, 6'd0, 8'h40, 1'b1, 3'd3);
    // only the 32-bit code left: zeros never match
    for (int i = 0; i < 4; i++) queue_op(ACT_LOAD, 8'(i), 32'd0, 6'd0, 8'd0, 1'b0, 3'd0);
    for (int i = 0; i < 4; i++) queue_op(ACT_DEC, 8'd0, 32'd0, 6'd0, 8'h00, 1'b0, 3'd7);
    queue_op(ACT_DEC, 8'd0, 32'd0, 6'd0, 8'hFF, 1'b1, 3'd0);
    queue_op(ACT_LOAD, 8'd255, 32'd0, 6'd0, 8'd0, 1'b0, 3'd0);
    queue_op(ACT_END, 8'd0, 32'd0, 6'd0, 8'd0, 1'b0, 3'd0);

    while (op_q.size() < 400) begin
      if ($urandom_range(99) < 15) begin
        k = $urandom_range(1, 4);
        repeat (k) queue_noise();
      end else begin
        if (table_empty() || $urandom_range(99) < 30) begin
          for (int i = 0; i < 256; i++) begin
            if (tbl_len[i] != 0) begin
              queue_op(ACT_LOAD, 8'(i), $urandom, 6'd0, 8'($urandom), 1'b0, 3'd0);
            end
          end
          lf_bits = '{32'd0, 32'd1};
          lf_len = '{1, 1};
          m = $urandom_range(0, 10);
          repeat (m) begin
            k = $urandom_range(lf_len.size() - 1);
            if (lf_len[k] < 12) begin
              lf_bits.push_back({lf_bits[k][30:0], 1'b1});
              lf_len.push_back(lf_len[k] + 1);
              lf_bits[k] = {lf_bits[k][30:0], 1'b0};
              lf_len[k] = lf_len[k] + 1;
            end
          end
          taken = '{default: 1'b0};
          foreach (lf_len[i]) begin
            do s = $urandom_range(255); while (taken[s]);
            taken[s] = 1'b1;
            // random bits above the code length must be ignored
            queue_op(ACT_LOAD, 8'(s), lf_bits[i] | ($urandom << lf_len[i]), 6'(lf_len[i]),
                     8'($urandom), 1'($urandom), 3'($urandom));
          end
        end
        syms.delete();
        k = $urandom_range(0, 6);
        repeat (k) begin
          do s = $urandom_range(255); while (tbl_len[s] == 0 && $urandom_range(9) != 0);
          syms.push_back(s);
        end
        encode_decode(syms, 1'b1);
      end
    end
  endtask

  function automatic bit calm();
    return sent_cnt >= 150 && sent_cnt < 230;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (op_q.size() > 0 && (calm() || $urandom_range(99) >= 24)) begin
        op_t w;
        w = op_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= w.act;
        in_tlast  <= w.fin;
        in_tdata  <= {7'd0, w.tail, w.byt, w.len, w.code, w.sym};
        sent_cnt  <= sent_cnt + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm() || $urandom_range(99) >= 24;
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          err_cnt <= err_cnt + 1;
          if (err_cnt < 10) $display("tb_top: unexpected result word %h kind %0d",
                                     out_tdata, out_tuser);
        end else begin
          outw_t e;
          e = result_q.pop_front();
          if (out_tuser !== e.kind || out_tdata[7:0] !== e.value ||
              out_tdata[11:8] !== e.used || out_tdata[13:12] !== e.err ||
              out_tdata[15:14] !== 2'd0 || out_tlast !== e.last) begin
            err_cnt <= err_cnt + 1;
            if (err_cnt < 10)
              $display({"tb_top: mismatch exp kind %0d val %h used %0d err %0d last %0d,",
                        " got kind %0d val %h used %0d err %0d last %0d (tdata %h)"},
                       e.kind, e.value, e.used, e.err, e.last, out_tuser, out_tdata[7:0],
                       out_tdata[11:8], out_tdata[13:12], out_tlast, out_tdata);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 64'd0;
    in_tuser = 2'd0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    sent_cnt = 0;
    err_cnt = 0;
    tbl_code = '{default: 32'd0};
    tbl_len = '{default: 6'd0};
    pk_bits = 8'd0; pk_cnt = 3'd0; msg_open = 1'b0; mbuf = 32'd0; mlen = 6'd0;
    fill_stimulus();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (op_q.size() > 0 || in_tvalid) @(posedge clk);
    while (result_q.size() > 0) @(posedge clk);
    // a decode word may still be scanning with no result to come
    repeat (6000) @(posedge clk);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== prefix_code_pack_unpack_unit.f =====
hdl/pcpu_pkg.sv
hdl/pcpu_ctrl.sv
hdl/pcpu_dp.sv
hdl/prefix_code_pack_unpack_unit.sv
test/tb_top.sv
